>>> hdl/hashed_tag_cache_lru_assert.svh
// assertion macros shared by the cache checker
`ifndef HASHED_TAG_CACHE_LRU_ASSERT_SVH
`define HASHED_TAG_CACHE_LRU_ASSERT_SVH

// same-cycle implication, reset masked
`define HCL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hcl check failed");

// next-cycle implication, reset masked
`define HCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hcl check failed");

`endif

>>> hdl/hcl_pkg.sv
// shared types and constants of the hashed tag cache
`timescale 1ns / 1ps
`default_nettype none

package hcl_pkg;

  localparam int LINES   = 10;
  localparam int LINE_W  = 6;
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 17;
  localparam int STAMP_W = 64;
  localparam int CFG_W   = 18;

  localparam logic [CFG_W-1:0] MAX_OBJ_RESET = CFG_W'(102400);

  typedef logic [LINE_W-1:0]  line_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  // running search result handed from cell to cell
  typedef struct packed {
    logic   vld;
    logic   found;
    line_t  hit_idx;
    len_t   hit_len;
    logic   have_free;
    line_t  free_idx;
    logic   min_set;
    stamp_t min_stamp;
    line_t  min_idx;
  } scan_t;

  // update broadcast to all cells
  typedef struct packed {
    logic   wr;
    logic   stamp;
    line_t  idx;
    key_t   key;
    len_t   len;
    stamp_t now;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/hcl_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface hcl_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [hcl_pkg::KEY_W-1:0] key;
  logic [hcl_pkg::LEN_W-1:0] length;

  modport source (output valid, func, key, length, input ready);
  modport sink   (input valid, func, key, length, output ready);
endinterface

interface hcl_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       written;
  logic [hcl_pkg::LINE_W-1:0] line;
  logic [hcl_pkg::LEN_W-1:0]  stored_length;

  modport source (output valid, hit, written, line, stored_length, input ready);
  modport sink   (input valid, hit, written, line, stored_length, output ready);
endinterface

`default_nettype wire

>>> hdl/hcl_cell.sv
// one cache line with its stage of the search chain
`timescale 1ns / 1ps
`default_nettype none

module hcl_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hcl_pkg::line_t idx_i,
  input  hcl_pkg::key_t  key_i,
  input  hcl_pkg::scan_t scan_i,
  input  hcl_pkg::cmd_t  cmd_i,
  output hcl_pkg::scan_t scan_o
);
  import hcl_pkg::*;

  logic   valid_q;
  key_t   tag_q;
  len_t   len_q;
  stamp_t stamp_q;
  scan_t  scan_d, scan_q;
  logic   sel;

  assign sel = (cmd_i.idx == idx_i);

  always_comb begin
    scan_d = scan_i;
    if (scan_i.vld) begin
      if (!scan_i.found && valid_q && (tag_q == key_i)) begin
        scan_d.found   = 1'b1;
        scan_d.hit_idx = idx_i;
        scan_d.hit_len = len_q;
      end
      if (!scan_i.have_free && !valid_q) begin
        scan_d.have_free = 1'b1;
        scan_d.free_idx  = idx_i;
      end
      // strictly smaller keeps the lowest line on ties
      if (!scan_i.min_set || (stamp_q < scan_i.min_stamp)) begin
        scan_d.min_set   = 1'b1;
        scan_d.min_stamp = stamp_q;
        scan_d.min_idx   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      scan_q <= scan_d;
      if (cmd_i.wr && sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && sel) begin
      tag_q <= cmd_i.key;
      len_q <= cmd_i.len;
    end
    if ((cmd_i.wr || cmd_i.stamp) && sel) begin
      stamp_q <= cmd_i.now;
    end
  end

  assign scan_o = scan_q;

endmodule

`default_nettype wire

>>> hdl/hashed_tag_cache_lru.sv
// top level of the hashed tag cache with timestamp lru replacement
//
//  port        dir   role
//  ----------  ----  ----------------------------------------------
//  req_i       sink  request beat: func, key, length
//  rsp_o       src   response beat: hit, written, line, stored_length
//  cfg_we_i    in    write strobe for max_object_bytes
//  cfg_wdata_i in    value for max_object_bytes
//
//  lookup and accepted fill: request latched, then the search token walks the
//  cell chain one line per cycle, the result is registered and commit loads the response
//  tick, refused fill, unused code: no search, straight to commit
//  one request in flight; req_i.ready is high only while idle
//  a stalled response holds the block in commit; no line changes until it drains
//  reset empties every line, zeroes the clock and restores max_object_bytes
`timescale 1ns / 1ps
`default_nettype none

module hashed_tag_cache_lru (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hcl_pkg::CFG_W-1:0] cfg_wdata_i,
  hcl_req_if.sink                   req_i,
  hcl_rsp_if.source                 rsp_o
);
  import hcl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // latched request
  logic [1:0] func_q;
  key_t       key_q;
  len_t       len_q;
  logic       fill_ok_q;

  logic [CFG_W-1:0] max_q;
  stamp_t           time_q;

  // search chain
  logic  inject_q;
  scan_t scan_init;
  scan_t scan_chain [LINES];
  scan_t res_q;
  cmd_t  cmd;

  // response register
  logic  out_vld_q;
  logic  out_hit_q, out_wr_q;
  line_t out_line_q;
  len_t  out_len_q;

  logic  accept, fill_ok, needs_scan, commit;
  logic  is_hit, is_wr;
  line_t victim;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // fill gate: non-zero and strictly below the configured limit
  assign fill_ok    = (req_i.length != '0) && ({1'b0, req_i.length} < max_q);
  assign needs_scan = (req_i.func == FUNC_LOOKUP) ||
                      ((req_i.func == FUNC_FILL) && fill_ok);

  // token enters cell 0 with an empty running result
  always_comb begin
    scan_init     = '0;
    scan_init.vld = inject_q;
  end

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    hcl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (line_t'(g)),
      .key_i  (key_q),
      .scan_i ((g == 0) ? scan_init : scan_chain[(g == 0) ? 0 : g - 1]),
      .cmd_i  (cmd),
      .scan_o (scan_chain[g])
    );
  end

  // commit waits for the response register to be free
  assign commit = (state_q == ST_COMMIT) && (!out_vld_q || rsp_o.ready);

  assign is_hit = (func_q == FUNC_LOOKUP) && res_q.found;
  assign is_wr  = (func_q == FUNC_FILL) && fill_ok_q;
  // first empty line, else oldest stamp
  assign victim = res_q.have_free ? res_q.free_idx : res_q.min_idx;

  always_comb begin
    cmd       = '0;
    cmd.wr    = commit && is_wr;
    cmd.stamp = commit && is_hit;
    cmd.idx   = is_hit ? res_q.hit_idx : victim;
    cmd.key   = key_q;
    cmd.len   = len_q;
    cmd.now   = time_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = needs_scan ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (scan_chain[LINES-1].vld) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      inject_q  <= 1'b0;
      max_q     <= MAX_OBJ_RESET;
      time_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      inject_q <= accept && needs_scan;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (commit && (func_q == FUNC_TICK)) begin
        time_q <= time_q + STAMP_W'(1);
      end
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= req_i.func;
      key_q     <= req_i.key;
      len_q     <= req_i.length;
      fill_ok_q <= fill_ok;
    end
    if ((state_q == ST_SCAN) && scan_chain[LINES-1].vld) begin
      res_q <= scan_chain[LINES-1];
    end
    if (commit) begin
      out_hit_q  <= is_hit;
      out_wr_q   <= is_wr;
      out_line_q <= is_hit ? res_q.hit_idx : (is_wr ? victim : '0);
      out_len_q  <= is_hit ? res_q.hit_len : '0;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.written       = out_wr_q;
  assign rsp_o.line          = out_line_q;
  assign rsp_o.stored_length = out_len_q;

endmodule

`default_nettype wire

>>> hdl/hcl_checker.sv
// port-level checker for the hashed tag cache, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_tag_cache_lru_assert.svh"

module hcl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_hit_i,
  input logic                       out_written_i,
  input logic [hcl_pkg::LINE_W-1:0] out_line_i,
  input logic [hcl_pkg::LEN_W-1:0]  out_len_i
);
  import hcl_pkg::*;

  // stalled response beat keeps its payload
  `HCL_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_line_i) && $stable(out_hit_i) && $stable(out_written_i) && $stable(out_len_i))
  // a beat is a hit or a write, never both
  `HCL_ASSERT_NOW(a_one_kind, clk_i, rst_ni, out_valid_i, !(out_hit_i && out_written_i))
  // length only reported on a hit
  `HCL_ASSERT_NOW(a_miss_len, clk_i, rst_ni, out_valid_i && !out_hit_i, out_len_i == '0)
  // line zero when nothing matched or stored
  `HCL_ASSERT_NOW(a_idle_line, clk_i, rst_ni, out_valid_i && !out_hit_i && !out_written_i, out_line_i == '0)
  // one request in flight at a time
  `HCL_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind hashed_tag_cache_lru hcl_checker u_hcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_hit_i     (rsp_o.hit),
  .out_written_i (rsp_o.written),
  .out_line_i    (rsp_o.line),
  .out_len_i     (rsp_o.stored_length)
);

`default_nettype wire
